[design/bdpc_pkg.sv]
`default_nettype none

package bdpc_pkg;

   // time arithmetic is modulo 2^TIME_WIDTH; matches the timestamp field
   localparam int TIME_WIDTH = 32;
   localparam int CFG_WIDTH  = 16;
   localparam int EV_WIDTH   = 3;
   localparam int IDX_WIDTH  = 1;

   // request and response packing
   localparam int REQ_FIELDS_W = 1 + TIME_WIDTH;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((EV_WIDTH + 7) / 8) * 8;

   // register indexes
   localparam logic [IDX_WIDTH-1:0] REG_DEBOUNCE_TIME   = 1'd0;
   localparam logic [IDX_WIDTH-1:0] REG_LONG_PRESS_TIME = 1'd1;

   // event codes
   localparam logic [EV_WIDTH-1:0] EV_NONE     = 3'd0;
   localparam logic [EV_WIDTH-1:0] EV_PRESSED  = 3'd1;
   localparam logic [EV_WIDTH-1:0] EV_SHORT    = 3'd2;
   localparam logic [EV_WIDTH-1:0] EV_LONG     = 3'd3;
   localparam logic [EV_WIDTH-1:0] EV_RELEASED = 3'd4;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_time;
      logic [CFG_WIDTH-1:0] long_press_time;
   } cfg_type;

   typedef struct packed {
      logic stable_level;
      logic long_reported;
   } status_type;

endpackage

`default_nettype wire

[design/button_debounce_press_classifier_top.sv]
`default_nettype none

// Button debounce and press classifier.
//
// Request channel (req_*): one sample per request, the raw button level and
// a millisecond timestamp. Response channel (rsp_*): exactly one event code
// per request, in request order (none, pressed, short press, long press,
// released).
// Configuration (csr_*): index 0 debounce time, index 1 long press time,
// both 16 bit; write only while no request is in flight.
//
// A request goes to the sample register, then the response register that
// drives rsp_tvalid. Throughput: one request per cycle unless stalled; the
// sample register feeds one pass of subtract and compare logic that updates
// the button state and loads the response register in the same cycle.
// When the receiver stalls, the response register holds its event and the
// sample register holds one more request; req_tready then drops until the
// response is taken.
// Reset (synchronous, active high) empties both registers, clears the
// button state and restores debounce 50 ms and long press 1000 ms.

module button_debounce_press_classifier_top
   import bdpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // raw_level, now_time, zero fill
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // event_res, zero fill
   input  wire logic                  csr_wr_en,
   input  wire logic [IDX_WIDTH-1:0]  csr_index,
   input  wire logic [CFG_WIDTH-1:0]  csr_wdata
);

   cfg_type    cfg;
   status_type status;

   // sample register
   logic                  smp_valid_ff, smp_valid_in;
   logic                  smp_raw_ff;
   logic [TIME_WIDTH-1:0] smp_time_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EV_WIDTH-1:0]   rsp_event_ff;

   logic                  advance;
   logic                  req_take;
   logic [EV_WIDTH-1:0]   event_res;

   // the sample moves on whenever the response slot is free or being emptied
   assign advance    = smp_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !smp_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign smp_valid_in = req_take || (smp_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         smp_valid_ff <= smp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         smp_raw_ff  <= req_tdata[0];
         smp_time_ff <= req_tdata[TIME_WIDTH:1];
      end
      if (advance) begin
         rsp_event_ff <= event_res;
      end
   end

   bdpc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bdpc_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .raw_level (smp_raw_ff),
      .now_time  (smp_time_ff),
      .cfg       (cfg),
      .event_res (event_res),
      .status    (status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - EV_WIDTH){1'b0}}, rsp_event_ff};

   // a long press event leaves the latch set
   a_long_latch: assert property (@(posedge clock) disable iff (reset)
      advance && (event_res == EV_LONG) |=> status.long_reported)
      else $error("long press reported without latching");

   // a press event leaves the button down with the latch cleared
   a_press_state: assert property (@(posedge clock) disable iff (reset)
      advance && (event_res == EV_PRESSED) |=> status.stable_level && !status.long_reported)
      else $error("press event without state update");

   // no long press while the button is up
   a_long_needs_press: assert property (@(posedge clock) disable iff (reset)
      advance && (event_res == EV_LONG) |-> status.stable_level)
      else $error("long press while released");

   // a held sample with a stalled response blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      smp_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while pipeline full");

   // reset leaves both registers empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

[design/bdpc_cfg.sv]
`default_nettype none

module bdpc_cfg
   import bdpc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [IDX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_WIDTH-1:0] csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_DEBOUNCE_TIME:   cfg_in.debounce_time   = csr_wdata;
            REG_LONG_PRESS_TIME: cfg_in.long_press_time = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= DEBOUNCE_RESET;
         cfg_ff.long_press_time <= LONG_PRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[design/bdpc_classify.sv]
`default_nettype none

module bdpc_classify
   import bdpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  raw_level,
   input  wire logic [TIME_WIDTH-1:0] now_time,
   input  wire cfg_type               cfg,
   output logic [EV_WIDTH-1:0]        event_res,
   output status_type                 status
);

   logic                  last_raw_ff,          last_raw_in;
   logic                  stable_level_ff,      stable_level_in;
   logic [TIME_WIDTH-1:0] raw_change_stamp_ff,  raw_change_stamp_in;
   logic [TIME_WIDTH-1:0] press_start_stamp_ff, press_start_stamp_in;
   logic                  long_reported_ff,     long_reported_in;

   logic [TIME_WIDTH-1:0] since_change;
   logic [TIME_WIDTH-1:0] since_press;
   logic                  edge_ok;

   assign last_raw_in         = raw_level;
   assign raw_change_stamp_in = (raw_level != last_raw_ff) ? now_time : raw_change_stamp_ff;
   assign since_change        = now_time - raw_change_stamp_in;
   assign since_press         = now_time - press_start_stamp_ff;
   assign edge_ok = (last_raw_in != stable_level_ff) &&
                    (since_change >= TIME_WIDTH'(cfg.debounce_time));

   always_comb begin
      stable_level_in      = stable_level_ff;
      press_start_stamp_in = press_start_stamp_ff;
      long_reported_in     = long_reported_ff;
      event_res            = EV_NONE;
      if (edge_ok) begin
         stable_level_in = last_raw_in;
         if (last_raw_in) begin
            press_start_stamp_in = now_time;
            long_reported_in     = 1'b0;
            event_res            = EV_PRESSED;
         end else begin
            event_res = long_reported_ff ? EV_RELEASED : EV_SHORT;
         end
      end else if (stable_level_ff && !long_reported_ff && (cfg.long_press_time != '0) &&
                   (since_press >= TIME_WIDTH'(cfg.long_press_time))) begin
         long_reported_in = 1'b1;
         event_res        = EV_LONG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff          <= 1'b0;
         stable_level_ff      <= 1'b0;
         raw_change_stamp_ff  <= '0;
         press_start_stamp_ff <= '0;
         long_reported_ff     <= 1'b0;
      end else if (advance) begin
         last_raw_ff          <= last_raw_in;
         stable_level_ff      <= stable_level_in;
         raw_change_stamp_ff  <= raw_change_stamp_in;
         press_start_stamp_ff <= press_start_stamp_in;
         long_reported_ff     <= long_reported_in;
      end
   end

   assign status.stable_level  = stable_level_ff;
   assign status.long_reported = long_reported_ff;

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb
   import bdpc_pkg::*;
();

   // one raw button sample as offered on the request channel
   typedef struct {
      logic                  raw;
      logic [TIME_WIDTH-1:0] stamp;
   } sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // raw_level, now_time, zero fill
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // event_res, zero fill
   logic                  csr_wr_en = 1'b0;
   logic [IDX_WIDTH-1:0]  csr_index = '0;
   logic [CFG_WIDTH-1:0]  csr_wdata = '0;

   button_debounce_press_classifier_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // stimulus queue, expected events and bookkeeping
   sample_type            pending_samples[$];
   logic [EV_WIDTH-1:0]   expected_events[$];
   int unsigned           n_queued = 0;
   int unsigned           n_accepted = 0;
   int unsigned           errors = 0;
   logic [TIME_WIDTH-1:0] cur_time = '0;

   // idling control: gaps on/off per phase, plus one long receiver hold-off
   logic                  idle_on = 1'b0;
   logic                  hold_req = 1'b0;
   logic                  hold_ack = 1'b0;
   int unsigned           hold_cnt = 0;
   int unsigned           tx_gap = 0;
   int unsigned           rx_gap = 0;

   // predictor's copy of configuration and button state
   logic [CFG_WIDTH-1:0]  model_debounce = DEBOUNCE_RESET;
   logic [CFG_WIDTH-1:0]  model_long_press = LONG_PRESS_RESET;
   logic                  seen_raw = 1'b0;
   logic                  debounced = 1'b0;
   logic [TIME_WIDTH-1:0] change_stamp = '0;
   logic [TIME_WIDTH-1:0] hold_start = '0;
   logic                  long_seen = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Debounce and classify one sample; updates the predictor's button state.
   // Differences wrap modulo 2^TIME_WIDTH, so backwards timestamps look old.
   function automatic logic [EV_WIDTH-1:0] classify_sample(input logic raw,
                                                           input logic [TIME_WIDTH-1:0] now);
      logic [EV_WIDTH-1:0]   ev;
      logic [TIME_WIDTH-1:0] since_change;
      logic [TIME_WIDTH-1:0] held_for;
      ev = EV_NONE;
      if (raw != seen_raw) begin
         seen_raw = raw;
         change_stamp = now;
      end
      since_change = now - change_stamp;
      held_for = now - hold_start;
      if (seen_raw != debounced && since_change >= TIME_WIDTH'(model_debounce)) begin
         debounced = seen_raw;
         if (debounced) begin
            hold_start = now;
            long_seen = 1'b0;
            ev = EV_PRESSED;
         end else begin
            ev = long_seen ? EV_RELEASED : EV_SHORT;
         end
      end else if (debounced && !long_seen && model_long_press != '0 &&
                   held_for >= TIME_WIDTH'(model_long_press)) begin
         // an edge on this sample would have masked the long press
         long_seen = 1'b1;
         ev = EV_LONG;
      end
      return ev;
   endfunction

   // mostly back to back, sometimes a short gap, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [EV_WIDTH-1:0] got,
                                  input logic [EV_WIDTH-1:0] want);
      if (errors < 40)
         $display("ERROR %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // ------------------------------------------------------------------
   // Driver: offers pending requests, predicts each one as it is taken
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      sample_type            s;
      logic [REQ_DATA_W-1:0] word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_events.push_back(classify_sample(req_tdata[0],
                                                      req_tdata[TIME_WIDTH:1]));
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (tx_gap != 0) begin
               tx_gap <= tx_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               s = pending_samples.pop_front();
               word = '0;
               word[0] = s.raw;
               word[TIME_WIDTH:1] = s.stamp;
               req_tdata <= word;
               req_tvalid <= 1'b1;
               tx_gap <= idle_on ? pick_gap() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each response against the oldest expected event
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      logic [EV_WIDTH-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata[EV_WIDTH-1:0], EV_NONE);
            end else begin
               want = expected_events.pop_front();
               if (rsp_tdata[EV_WIDTH-1:0] !== want)
                  report_mismatch("event_res", rsp_tdata[EV_WIDTH-1:0], want);
            end
         end
         if (rx_gap != 0) begin
            rx_gap <= rx_gap - 1;
            rsp_tready <= 1'b0;
         end else if (hold_cnt != 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rx_gap <= idle_on ? pick_gap() : 0;
         end
      end
   end

   // long receiver hold-off, started by toggling hold_req
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
         hold_ack <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (hold_ack != hold_req) begin
         hold_ack <= hold_req;
         hold_cnt <= 400;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic add_sample(input logic raw, input logic [TIME_WIDTH-1:0] stamp);
      sample_type s;
      s.raw = raw;
      s.stamp = stamp;
      pending_samples.push_back(s);
      n_queued++;
   endtask

   // wait until every request is taken and every response has come back
   task automatic drain();
      while (n_accepted != n_queued || expected_events.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == REG_DEBOUNCE_TIME)
         model_debounce = val;
      else if (idx == REG_LONG_PRESS_TIME)
         model_long_press = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One press and release with bounce on both edges; step sizes follow the
   // current settings so debounce and long press are crossed or not at random.
   task automatic add_press_cycle();
      int unsigned bounce_span;
      int unsigned hold_span;
      bounce_span = model_debounce / 2 + 2;
      hold_span = (int'(model_debounce) + int'(model_long_press)) / 3 + 2;
      repeat ($urandom_range(0, 4)) begin
         cur_time += $urandom_range(0, bounce_span);
         add_sample(1'($urandom_range(0, 1)), cur_time);
      end
      repeat ($urandom_range(1, 8)) begin
         cur_time += $urandom_range(0, hold_span);
         add_sample(1'b1, cur_time);
      end
      repeat ($urandom_range(0, 4)) begin
         cur_time += $urandom_range(0, bounce_span);
         add_sample(1'($urandom_range(0, 1)), cur_time);
      end
      repeat ($urandom_range(1, 5)) begin
         cur_time += $urandom_range(0, 2 * bounce_span);
         add_sample(1'b0, cur_time);
      end
   endtask

   // well-formed press cycles, with noise and timestamp jumps mixed in
   task automatic add_random_requests(input int unsigned count);
      int unsigned target;
      int unsigned r;
      target = n_queued + count;
      while (n_queued < target) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            repeat ($urandom_range(1, 4))
               add_sample(1'($urandom_range(0, 1)), $urandom);
         end else if (r < 15) begin
            cur_time = $urandom;   // may go backwards
         end else begin
            add_press_cycle();
         end
      end
   endtask

   task automatic run_phase(input logic [CFG_WIDTH-1:0] dbt, input logic [CFG_WIDTH-1:0] lpt,
                            input int unsigned count, input logic gaps);
      write_reg(REG_DEBOUNCE_TIME, dbt);
      write_reg(REG_LONG_PRESS_TIME, lpt);
      @(negedge clock);
      idle_on = gaps;
      cur_time = $urandom;
      add_random_requests(count);
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed requests at reset settings (50 ms debounce, 1000 ms hold)
      add_sample(1'b0, 32'h0000_0000);
      add_sample(1'b1, 32'd10);
      add_sample(1'b1, 32'd59);         // one short of debounce
      add_sample(1'b1, 32'd60);         // pressed
      add_sample(1'b1, 32'd1059);
      add_sample(1'b1, 32'd1060);       // long press
      add_sample(1'b1, 32'd5000);       // already reported
      add_sample(1'b0, 32'd5010);       // bounce on release
      add_sample(1'b1, 32'd5020);
      add_sample(1'b0, 32'd5030);
      add_sample(1'b0, 32'd5080);       // released after long press
      add_sample(1'b1, 32'd5100);
      add_sample(1'b1, 32'd5150);       // pressed
      add_sample(1'b0, 32'd5300);
      add_sample(1'b0, 32'd9000);       // release edge masks an overdue long press
      add_sample(1'b1, 32'hFFFF_FFF0);
      add_sample(1'b1, 32'h0000_0022);  // debounce across the wrap
      add_sample(1'b1, 32'h0000_0010);  // timestamp goes backwards
      add_sample(1'b0, 32'hFFFF_FFFF);
      add_sample(1'b0, 32'h7FFF_FFFF);
      drain();

      // zero debounce and long press disabled
      write_reg(REG_DEBOUNCE_TIME, 16'd0);
      write_reg(REG_LONG_PRESS_TIME, 16'd0);
      @(negedge clock);
      add_sample(1'b1, 32'h8000_0000);  // accepted on the same sample
      add_sample(1'b1, 32'hFFFF_0000);
      add_sample(1'b0, 32'hFFFF_0001);
      drain();

      run_phase(16'd0, 16'd0, 250, 1'b1);
      run_phase(16'hFFFF, 16'hFFFF, 250, 1'b0);

      // receiver holds off for a long stretch while requests keep coming
      write_reg(REG_DEBOUNCE_TIME, DEBOUNCE_RESET);
      write_reg(REG_LONG_PRESS_TIME, LONG_PRESS_RESET);
      @(negedge clock);
      idle_on = 1'b1;
      cur_time = $urandom;
      add_random_requests(300);
      hold_req = ~hold_req;
      drain();

      // sender pauses midway until every response is back
      write_reg(REG_DEBOUNCE_TIME, CFG_WIDTH'($urandom_range(0, 200)));
      write_reg(REG_LONG_PRESS_TIME, CFG_WIDTH'($urandom_range(1, 3000)));
      @(negedge clock);
      cur_time = $urandom;
      add_random_requests(150);
      drain();
      add_random_requests(150);
      drain();

      run_phase(16'd1, 16'd1, 250, 1'b0);
      run_phase(CFG_WIDTH'($urandom), CFG_WIDTH'($urandom), 250, 1'b1);

      repeat (5) @(posedge clock);
      @(negedge clock);
      if (expected_events.size() != 0)
         report_mismatch("missing responses", '0, EV_WIDTH'(expected_events.size()));
      if (errors == 0)
         $display("button_debounce_press_classifier_top: match");
      else
         $display("button_debounce_press_classifier_top: mismatch");
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #20_000_000;
      $display("button_debounce_press_classifier_top: mismatch");
      $finish;
   end

endmodule
